// ===== hw/rtl/udpc_pkg.sv =====
// ----------------------------------------------------------------------------
// udpc_pkg
// Shared constants, types and microcode encoding of the up/down digipot
// controller.
// ----------------------------------------------------------------------------
package udpc_pkg;

    localparam int NUM_CHANNELS = 6;   // 1 .. 6
    localparam int WIPER_STEPS  = 64;  // 2 .. 64

    // Fixed field widths of the channels
    localparam int CMD_W     = 1;
    localparam int CHAN_W    = 3;
    localparam int TARGET_W  = 8;
    localparam int MASK_W    = 6;
    localparam int STEP_IDX_W = 6;

    localparam int POS_W    = $clog2(WIPER_STEPS);
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [POS_W-1:0]  TOP_POS  = POS_W'(WIPER_STEPS - 1);
    localparam logic [MASK_W-1:0] ALL_MASK = MASK_W'((1 << NUM_CHANNELS) - 1);

    localparam logic [CMD_W-1:0] CMD_INIT = 1'b0;
    localparam logic [CMD_W-1:0] CMD_SET  = 1'b1;

    // Microcode addresses
    localparam int UADDR_W = 3;
    typedef logic [UADDR_W-1:0] uaddr_t;

    localparam uaddr_t UA_FETCH  = 3'd0;
    localparam uaddr_t UA_DECODE = 3'd1;
    localparam uaddr_t UA_CHKSET = 3'd2;
    localparam uaddr_t UA_LDSET  = 3'd3;
    localparam uaddr_t UA_LDINIT = 3'd4;
    localparam uaddr_t UA_EMIT   = 3'd5;
    localparam uaddr_t UA_DONE   = 3'd6;

    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN_ACC   = 3'd1,
        COND_IS_INIT  = 3'd2,
        COND_SKIP     = 3'd3,
        COND_OUT_FREE = 3'd4,
        COND_NOT_LAST = 3'd5,
        COND_NEVER    = 3'd6
    } cond_t;

    // One control word per microcode step
    typedef struct packed {
        logic   accept_in;  // input channel ready during this step
        logic   load_set;   // set up a run for one channel
        logic   load_init;  // set up the all-channel init run
        logic   emit;       // push one step result when the output slot is free
        cond_t  wait_cond;  // stay on this step until true
        cond_t  jmp_cond;   // jump when true, else fall through
        uaddr_t jmp_addr;
    } ctrl_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_acc;
        logic is_init;
        logic skip;
        logic out_free;
        logic last;
    } flags_t;

endpackage

// ===== hw/rtl/udpc_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// udpc_ucode_rom
// Read-only microprogram: maps the step counter to a control word.
// ----------------------------------------------------------------------------
module udpc_ucode_rom (
    input  udpc_pkg::uaddr_t upc,
    output udpc_pkg::ctrl_t  ctrl
);

    function automatic udpc_pkg::ctrl_t word(
        input logic             acc,
        input logic             lset,
        input logic             linit,
        input logic             emt,
        input udpc_pkg::cond_t  wc,
        input udpc_pkg::cond_t  jc,
        input udpc_pkg::uaddr_t ja
    );
        udpc_pkg::ctrl_t w;
        w.accept_in = acc;
        w.load_set  = lset;
        w.load_init = linit;
        w.emit      = emt;
        w.wait_cond = wc;
        w.jmp_cond  = jc;
        w.jmp_addr  = ja;
        return w;
    endfunction

    always_comb begin
        unique case (upc)
            udpc_pkg::UA_FETCH:
                ctrl = word(1'b1, 1'b0, 1'b0, 1'b0, udpc_pkg::COND_IN_ACC,
                            udpc_pkg::COND_NEVER, udpc_pkg::UA_FETCH);
            udpc_pkg::UA_DECODE:
                ctrl = word(1'b0, 1'b0, 1'b0, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_IS_INIT, udpc_pkg::UA_LDINIT);
            udpc_pkg::UA_CHKSET:
                ctrl = word(1'b0, 1'b0, 1'b0, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_SKIP, udpc_pkg::UA_FETCH);
            udpc_pkg::UA_LDSET:
                ctrl = word(1'b0, 1'b1, 1'b0, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_ALWAYS, udpc_pkg::UA_EMIT);
            udpc_pkg::UA_LDINIT:
                ctrl = word(1'b0, 1'b0, 1'b1, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_NEVER, udpc_pkg::UA_FETCH);
            udpc_pkg::UA_EMIT:
                ctrl = word(1'b0, 1'b0, 1'b0, 1'b1, udpc_pkg::COND_OUT_FREE,
                            udpc_pkg::COND_NOT_LAST, udpc_pkg::UA_EMIT);
            udpc_pkg::UA_DONE:
                ctrl = word(1'b0, 1'b0, 1'b0, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_ALWAYS, udpc_pkg::UA_FETCH);
            default:
                ctrl = word(1'b0, 1'b0, 1'b0, 1'b0, udpc_pkg::COND_ALWAYS,
                            udpc_pkg::COND_ALWAYS, udpc_pkg::UA_FETCH);
        endcase
    end

endmodule

// ===== hw/rtl/udpc_datapath.sv =====
// ----------------------------------------------------------------------------
// udpc_datapath
// Wiper position registers, run counters and the result output register.
// ----------------------------------------------------------------------------
module udpc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  udpc_pkg::ctrl_t                   ctrl,
    output udpc_pkg::flags_t                  flags,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [udpc_pkg::CMD_W-1:0]        s_cmd,
    input  logic [udpc_pkg::CHAN_W-1:0]       s_channel,
    input  logic [udpc_pkg::TARGET_W-1:0]     s_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [udpc_pkg::MASK_W-1:0]       m_select_mask,
    output logic                              m_step_up,
    output logic [udpc_pkg::STEP_IDX_W-1:0]   m_step_index,
    output logic                              m_last_step
);

    logic [udpc_pkg::CMD_W-1:0]      cmd_reg;
    logic [udpc_pkg::CHAN_W-1:0]     chan_reg;
    logic [udpc_pkg::TARGET_W-1:0]   target_reg;

    logic [udpc_pkg::POS_W-1:0]      wiper_reg [udpc_pkg::NUM_CHANNELS];

    logic [udpc_pkg::MASK_W-1:0]     run_mask_reg;
    logic                            run_up_reg;
    logic [udpc_pkg::POS_W-1:0]      cnt_m1_reg;
    logic [udpc_pkg::POS_W-1:0]      idx_reg;

    logic                            m_valid_reg;
    logic [udpc_pkg::MASK_W-1:0]     m_mask_reg;
    logic                            m_up_reg;
    logic [udpc_pkg::STEP_IDX_W-1:0] m_idx_reg;
    logic                            m_last_reg;

    logic                            in_acc;
    logic                            chan_ok;
    logic [udpc_pkg::CH_IDX_W-1:0]   ch_idx;
    logic [udpc_pkg::POS_W-1:0]      tgt;
    logic [udpc_pkg::POS_W-1:0]      cur;
    logic                            go_up;
    logic [udpc_pkg::POS_W-1:0]      diff;
    logic                            out_free;
    logic                            last;
    logic                            do_emit;

    // No transaction is taken while reset is held
    assign s_ready = ctrl.accept_in & aresetn;
    assign in_acc  = s_valid & s_ready;

    assign chan_ok = (chan_reg < udpc_pkg::CHAN_W'(udpc_pkg::NUM_CHANNELS));
    assign ch_idx  = chan_reg[udpc_pkg::CH_IDX_W-1:0];
    assign tgt     = (target_reg > udpc_pkg::TARGET_W'(udpc_pkg::WIPER_STEPS - 1))
                   ? udpc_pkg::TOP_POS : target_reg[udpc_pkg::POS_W-1:0];
    assign cur     = chan_ok ? wiper_reg[ch_idx] : udpc_pkg::TOP_POS;
    assign go_up   = (cur < tgt);
    assign diff    = go_up ? (tgt - cur) : (cur - tgt);

    assign out_free = ~m_valid_reg | m_ready;
    assign last     = (idx_reg == cnt_m1_reg);
    assign do_emit  = ctrl.emit & out_free;

    assign flags.in_acc   = in_acc;
    assign flags.is_init  = (cmd_reg == udpc_pkg::CMD_INIT);
    assign flags.skip     = ~chan_ok | (cur == tgt);
    assign flags.out_free = out_free;
    assign flags.last     = last;

    // Latched command
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            cmd_reg    <= s_cmd;
            chan_reg   <= s_channel;
            target_reg <= s_target;
        end
    end

    // Kept wiper positions
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.load_init) begin
            for (int i = 0; i < udpc_pkg::NUM_CHANNELS; i++) begin
                wiper_reg[i] <= udpc_pkg::TOP_POS;
            end
        end else if (ctrl.load_set) begin
            wiper_reg[ch_idx] <= tgt;
        end
    end

    // Run setup and step counter
    always_ff @(posedge aclk) begin
        if (ctrl.load_init) begin
            run_mask_reg <= udpc_pkg::ALL_MASK;
            run_up_reg   <= 1'b1;
            cnt_m1_reg   <= udpc_pkg::TOP_POS;
            idx_reg      <= '0;
        end else if (ctrl.load_set) begin
            run_mask_reg <= udpc_pkg::MASK_W'(1 << ch_idx);
            run_up_reg   <= go_up;
            cnt_m1_reg   <= diff - 1'b1;
            idx_reg      <= '0;
        end else if (do_emit) begin
            idx_reg      <= idx_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            m_mask_reg <= run_mask_reg;
            m_up_reg   <= run_up_reg;
            m_idx_reg  <= udpc_pkg::STEP_IDX_W'(idx_reg);
            m_last_reg <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_select_mask = m_mask_reg;
    assign m_step_up     = m_up_reg;
    assign m_step_index  = m_idx_reg;
    assign m_last_step   = m_last_reg;

endmodule

// ===== hw/rtl/updown_digipot_controller.sv =====
// A set is accepted in FETCH and passes DECODE, CHKSET and LDSET before EMIT, an init
//   passes DECODE and LDINIT. EMIT gives one step result per cycle while m_ready is high; a
//   command holds the sequencer until DONE, and a skipped set goes from CHKSET to FETCH.
// The rate is set by the single microcode step EMIT, which repeats until the last step.
// Reset (aresetn low, synchronous): all wiper positions read 63, no result pending.
// ----------------------------------------------------------------------------
// updown_digipot_controller
// Microcoded controller for six shared-line up/down digital potentiometers.
// ----------------------------------------------------------------------------
module updown_digipot_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [udpc_pkg::CMD_W-1:0]        s_cmd,
    input  logic [udpc_pkg::CHAN_W-1:0]       s_channel,
    input  logic [udpc_pkg::TARGET_W-1:0]     s_target,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [udpc_pkg::MASK_W-1:0]       m_select_mask,
    output logic                              m_step_up,
    output logic [udpc_pkg::STEP_IDX_W-1:0]   m_step_index,
    output logic                              m_last_step
);

    udpc_pkg::uaddr_t upc_reg;
    udpc_pkg::uaddr_t upc_next;
    udpc_pkg::ctrl_t  ctrl;
    udpc_pkg::flags_t flags;
    logic             wait_ok;
    logic             jmp_ok;

    function automatic logic eval_cond(input udpc_pkg::cond_t c,
                                       input udpc_pkg::flags_t f);
        logic r;
        unique case (c)
            udpc_pkg::COND_ALWAYS:   r = 1'b1;
            udpc_pkg::COND_IN_ACC:   r = f.in_acc;
            udpc_pkg::COND_IS_INIT:  r = f.is_init;
            udpc_pkg::COND_SKIP:     r = f.skip;
            udpc_pkg::COND_OUT_FREE: r = f.out_free;
            udpc_pkg::COND_NOT_LAST: r = ~f.last;
            udpc_pkg::COND_NEVER:    r = 1'b0;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    udpc_ucode_rom u_rom (
        .upc  (upc_reg),
        .ctrl (ctrl)
    );

    udpc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .flags         (flags),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_channel     (s_channel),
        .s_target      (s_target),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_select_mask (m_select_mask),
        .m_step_up     (m_step_up),
        .m_step_index  (m_step_index),
        .m_last_step   (m_last_step)
    );

    assign wait_ok = eval_cond(ctrl.wait_cond, flags);
    assign jmp_ok  = eval_cond(ctrl.jmp_cond, flags);

    // Hold on a pending wait, else branch or fall through
    always_comb begin
        priority if (!wait_ok) begin
            upc_next = upc_reg;
        end else if (jmp_ok) begin
            upc_next = ctrl.jmp_addr;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= udpc_pkg::UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    a_upc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg <= udpc_pkg::UA_DONE)
        else $error("microcode address out of program");

    a_mask_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_select_mask != '0))
        else $error("step result with no chip selected");

    a_down_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_step_up) |-> $onehot(m_select_mask))
        else $error("decrement step on more than one channel");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == udpc_pkg::UA_EMIT && flags.out_free && flags.last)
        |=> (upc_reg == udpc_pkg::UA_DONE && m_valid && m_last_step))
        else $error("final step did not end the run");

    a_no_input_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == udpc_pkg::UA_EMIT) |-> !s_ready)
        else $error("input taken while a run is in progress");

endmodule
